@@ rtl/patan2_pkg.sv @@
// Shared types and fixed-point constants of the cubic-polynomial atan2 pipeline.
package patan2_pkg;

	// Quotient bits of the ratio r, and fraction bits of r in Q1.15.
	localparam int Q_BITS = 16;
	localparam int R_FRAC = 15;
	localparam int R2_FRAC = 2 * R_FRAC;

	// Width of the angle result.
	localparam int OUT_W = 16;

	// Widths of the Q46 inner term, its split for the partial products, and the Q61 sum.
	localparam int INNER_W = 48;
	localparam int SPLIT_W = 24;
	localparam int SUM_W = 64;

	// Largest positive r in Q1.15.
	localparam logic [Q_BITS-1:0] R_MAX = {1'b0, {R_FRAC{1'b1}}};

	// Polynomial coefficients in Q16: 0.1963 and 0.9817.
	localparam logic [13:0] COEF_CUBE = 14'd12865;
	localparam logic [15:0] COEF_LIN = 16'd64337;
	localparam logic [INNER_W-1:0] LIN_Q46 = INNER_W'(COEF_LIN) << R2_FRAC;

	// pi/4 and 3pi/4 in Q61.
	localparam logic [SUM_W-1:0] PI_1_4 = 64'h1921_FB54_442D_1846;
	localparam logic [SUM_W-1:0] PI_3_4 = 64'h4B65_F1FC_CC87_48D2;

	// Saturation limits of the angle, by magnitude.
	localparam logic [OUT_W:0] LIM_POS = (OUT_W+1)'((1 << (OUT_W - 1)) - 1);
	localparam logic [OUT_W:0] LIM_NEG = (OUT_W+1)'(1 << (OUT_W - 1));

	// Sign flags that travel with each item.
	typedef struct packed {
		logic rneg;
		logic xneg;
		logic yneg;
	} flags_t;

endpackage

@@ rtl/patan2_front.sv @@
// Front end: epsilon-biased |y|, numerator and denominator, and the divider's dividend.
module patan2_front import patan2_pkg::*; #(
	parameter int IN_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [IN_WIDTH-1:0] vec_x,
	input  logic signed [IN_WIDTH-1:0] vec_y,
	output logic                       out_valid,
	output logic [IN_WIDTH:0]          out_rem,
	output logic [Q_BITS-1:0]          out_low,
	output logic [IN_WIDTH:0]          out_den,
	output flags_t                     out_flags
);

	localparam int N_W = IN_WIDTH + R_FRAC + 2;

	logic [2:0]                vld_s;
	logic [IN_WIDTH:0]         y_ext;
	logic [IN_WIDTH:0]         a_d;
	logic [IN_WIDTH:0]         a_s1;
	logic signed [IN_WIDTH-1:0] x_s1;
	flags_t                    fl_s1;
	logic [IN_WIDTH+1:0]       x_e;
	logic [IN_WIDTH+1:0]       a_e;
	logic [IN_WIDTH+1:0]       num_d;
	logic [IN_WIDTH+1:0]       den_d;
	logic [IN_WIDTH+1:0]       num_s2;
	logic [IN_WIDTH:0]         den_s2;
	flags_t                    fl_s2;
	logic [IN_WIDTH+1:0]       mag_d;
	logic [N_W-1:0]            n_d;
	logic [IN_WIDTH:0]         rem_s3;
	logic [Q_BITS-1:0]         low_s3;
	logic [IN_WIDTH:0]         den_s3;
	flags_t                    fl_s3;

	// Stage 1 logic: a = |y| + 1, with -y + 1 written as ~y + 2.
	assign y_ext = {vec_y[IN_WIDTH-1], vec_y};
	assign a_d = vec_y[IN_WIDTH-1] ? (~y_ext + (IN_WIDTH+1)'(2)) : (y_ext + (IN_WIDTH+1)'(1));

	// Stage 2 logic: numerator and denominator for the half plane of x.
	assign x_e = {{2{x_s1[IN_WIDTH-1]}}, x_s1};
	assign a_e = {1'b0, a_s1};
	assign num_d = fl_s1.xneg ? (x_e + a_e) : (x_e - a_e);
	assign den_d = fl_s1.xneg ? (a_e - x_e) : (x_e + a_e);

	// Stage 3 logic: dividend |num| * 2^15 + den / 2, split for the divider.
	assign mag_d = num_s2[IN_WIDTH+1] ? (~num_s2 + (IN_WIDTH+2)'(1)) : num_s2;
	assign n_d = N_W'({mag_d[IN_WIDTH:0], {R_FRAC{1'b0}}}) + N_W'(den_s2[IN_WIDTH:1]);

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[1:0], in_valid};
		end
	end

	// Stage payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_d;
			x_s1 <= vec_x;
			fl_s1.rneg <= 1'b0;
			fl_s1.xneg <= vec_x[IN_WIDTH-1];
			fl_s1.yneg <= vec_y[IN_WIDTH-1];

			num_s2 <= num_d;
			den_s2 <= den_d[IN_WIDTH:0];
			fl_s2 <= fl_s1;

			rem_s3 <= n_d[N_W-1:Q_BITS];
			low_s3 <= n_d[Q_BITS-1:0];
			den_s3 <= den_s2;
			fl_s3.rneg <= num_s2[IN_WIDTH+1];
			fl_s3.xneg <= fl_s2.xneg;
			fl_s3.yneg <= fl_s2.yneg;
		end
	end

	assign out_valid = vld_s[2];
	assign out_rem = rem_s3;
	assign out_low = low_s3;
	assign out_den = den_s3;
	assign out_flags = fl_s3;

	// The divider needs its starting remainder below the divisor.
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_rem < out_den))
		else $error("dividend start remainder not below divisor");

endmodule

@@ rtl/patan2_div.sv @@
// Pipelined restoring divider: one quotient bit of r per stage.
module patan2_div import patan2_pkg::*; #(
	parameter int IN_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IN_WIDTH:0] in_rem,
	input  logic [Q_BITS-1:0] in_low,
	input  logic [IN_WIDTH:0] in_den,
	input  flags_t            in_flags,
	output logic              out_valid,
	output logic [Q_BITS-1:0] out_q,
	output flags_t            out_flags
);

	logic              vld_s [Q_BITS];
	logic [IN_WIDTH:0] rem_s [Q_BITS];
	logic [Q_BITS-1:0] low_s [Q_BITS];
	logic [IN_WIDTH:0] den_s [Q_BITS];
	logic [Q_BITS-1:0] q_s   [Q_BITS];
	flags_t            fl_s  [Q_BITS];

	for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
		logic                vld_in;
		logic [IN_WIDTH:0]   rem_in;
		logic [Q_BITS-1:0]   low_in;
		logic [IN_WIDTH:0]   den_in;
		logic [Q_BITS-1:0]   q_in;
		flags_t              fl_in;
		logic [IN_WIDTH+1:0] trial;
		logic [IN_WIDTH+1:0] diff;
		logic                ge;

		// Stage input comes from the port or from the previous stage.
		if (i == 0) begin : g_first
			assign vld_in = in_valid;
			assign rem_in = in_rem;
			assign low_in = in_low;
			assign den_in = in_den;
			assign q_in = '0;
			assign fl_in = in_flags;
		end else begin : g_next
			assign vld_in = vld_s[i-1];
			assign rem_in = rem_s[i-1];
			assign low_in = low_s[i-1];
			assign den_in = den_s[i-1];
			assign q_in = q_s[i-1];
			assign fl_in = fl_s[i-1];
		end

		// Shift in the next dividend bit, then compare and subtract.
		assign trial = {rem_in, low_in[Q_BITS-1]};
		assign diff = trial - {1'b0, den_in};
		assign ge = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[IN_WIDTH:0] : trial[IN_WIDTH:0];
				low_s[i] <= {low_in[Q_BITS-2:0], 1'b0};
				den_s[i] <= den_in;
				q_s[i] <= {q_in[Q_BITS-2:0], ge};
				fl_s[i] <= fl_in;
			end
		end
	end

	assign out_valid = vld_s[Q_BITS-1];
	assign out_q = q_s[Q_BITS-1];
	assign out_flags = fl_s[Q_BITS-1];

	// With |num| <= den the rounded quotient never exceeds one in Q1.15.
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_q <= Q_BITS'(1 << R_FRAC)))
		else $error("divider quotient above one");

endmodule

@@ rtl/patan2_poly.sv @@
// Cubic polynomial in r, quadrant base, rounding and saturation of the angle.
module patan2_poly import patan2_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [Q_BITS-1:0] in_q,
	input  flags_t            in_flags,
	output logic              out_valid,
	output logic [OUT_W-1:0]  angle
);

	localparam int SH = 61 - ANGLE_FRAC_BITS;
	localparam int RW = SUM_W - SH;
	localparam int EW = (RW > OUT_W + 1) ? RW : OUT_W + 1;
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (SH - 1);

	logic [8:0]                      vld_s;
	logic [Q_BITS-1:0]               r_d;
	logic signed [Q_BITS-1:0]        r_s1;
	flags_t                          fl_s1;
	logic signed [2*Q_BITS-1:0]      sq_d;
	logic signed [Q_BITS-1:0]        r_s2;
	logic [R2_FRAC:0]                r2_s2;
	flags_t                          fl_s2;
	logic [R2_FRAC+14:0]             cube_d;
	logic [INNER_W-1:0]              inner_d;
	logic signed [INNER_W-1:0]       inner_s3;
	logic signed [Q_BITS-1:0]        r_s3;
	flags_t                          fl_s3;
	logic signed [SPLIT_W+Q_BITS:0]  pl_d;
	logic signed [INNER_W-SPLIT_W+Q_BITS-1:0] ph_d;
	logic signed [SPLIT_W+Q_BITS:0]  pl_s4;
	logic signed [INNER_W-SPLIT_W+Q_BITS-1:0] ph_s4;
	flags_t                          fl_s4;
	logic [SUM_W-1:0]                p_s5;
	flags_t                          fl_s5;
	logic [SUM_W-1:0]                sum_s6;
	logic                            yneg_s6;
	logic [SUM_W-1:0]                mag_s7;
	logic                            sgn_s7;
	logic [SUM_W-1:0]                rsum_d;
	logic [RW-1:0]                   rnd_s8;
	logic                            sgn_s8;
	logic [EW-1:0]                   rnd_ext;
	logic [EW-1:0]                   lim;
	logic [EW-1:0]                   capped;
	logic [OUT_W:0]                  cap_n;
	logic [OUT_W:0]                  neg_n;
	logic [OUT_W-1:0]                angle_s9;

	// Stage 1 logic: signed r in Q1.15, positive side saturated.
	assign r_d = in_flags.rneg ? (~in_q + Q_BITS'(1)) : (in_q[Q_BITS-1] ? R_MAX : in_q);

	// Stage 2 logic: r squared, exact in Q30.
	assign sq_d = r_s1 * r_s1;

	// Stage 3 logic: inner term 0.1963 r^2 - 0.9817 in Q46, always negative.
	assign cube_d = COEF_CUBE * r2_s2;
	assign inner_d = INNER_W'(cube_d) - LIN_Q46;

	// Stage 4 logic: inner times r as two partial products.
	assign pl_d = $signed({1'b0, inner_s3[SPLIT_W-1:0]}) * r_s3;
	assign ph_d = $signed(inner_s3[INNER_W-1:SPLIT_W]) * r_s3;

	// Stage 8 logic: round the magnitude half up to the output fraction.
	assign rsum_d = mag_s7 + HALF;

	// Stage 9 logic: saturate by magnitude, then apply the sign.
	assign rnd_ext = EW'(rnd_s8);
	assign lim = sgn_s8 ? EW'(LIM_NEG) : EW'(LIM_POS);
	assign capped = (rnd_ext > lim) ? lim : rnd_ext;
	assign cap_n = capped[OUT_W:0];
	assign neg_n = ~cap_n + (OUT_W+1)'(1);

	// Valid bits of the nine stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[7:0], in_valid};
		end
	end

	// Stage payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r_d;
			fl_s1 <= in_flags;

			r_s2 <= r_s1;
			r2_s2 <= sq_d[R2_FRAC:0];
			fl_s2 <= fl_s1;

			inner_s3 <= inner_d;
			r_s3 <= r_s2;
			fl_s3 <= fl_s2;

			pl_s4 <= pl_d;
			ph_s4 <= ph_d;
			fl_s4 <= fl_s3;

			p_s5 <= {ph_s4, {SPLIT_W{1'b0}}} +
				{{(SUM_W-SPLIT_W-Q_BITS-1){pl_s4[SPLIT_W+Q_BITS]}}, pl_s4};
			fl_s5 <= fl_s4;

			sum_s6 <= (fl_s5.xneg ? PI_3_4 : PI_1_4) + p_s5;
			yneg_s6 <= fl_s5.yneg;

			mag_s7 <= sum_s6[SUM_W-1] ? (~sum_s6 + SUM_W'(1)) : sum_s6;
			sgn_s7 <= sum_s6[SUM_W-1] ^ yneg_s6;

			rnd_s8 <= rsum_d[SUM_W-1:SH];
			sgn_s8 <= sgn_s7;

			angle_s9 <= sgn_s8 ? neg_n[OUT_W-1:0] : cap_n[OUT_W-1:0];
		end
	end

	assign out_valid = vld_s[8];
	assign angle = angle_s9;

	// The inner term stays below zero for every r.
	a_inner_neg: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[2] |-> inner_s3[INNER_W-1])
		else $error("inner polynomial term not negative");

endmodule

@@ rtl/patan2_obuf.sv @@
// Two-entry output buffer that decouples the pipeline from the result channel.
module patan2_obuf import patan2_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [OUT_W-1:0] push_angle,
	output logic             full,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_angle
);

	logic             head_v_q;
	logic             spare_v_q;
	logic [OUT_W-1:0] head_q;
	logic [OUT_W-1:0] spare_q;
	logic             pop;

	assign pop = head_v_q & out_ready;
	assign full = head_v_q & spare_v_q;

	// Occupancy: the head refills from the spare entry first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (!head_v_q || pop) begin
			head_v_q <= spare_v_q | push;
			spare_v_q <= spare_v_q & push;
		end else if (push) begin
			spare_v_q <= 1'b1;
		end
	end

	// Data of the two entries.
	always_ff @(posedge clk) begin
		if (!head_v_q || pop) begin
			if (spare_v_q) begin
				head_q <= spare_q;
				if (push) begin
					spare_q <= push_angle;
				end
			end else if (push) begin
				head_q <= push_angle;
			end
		end else if (push) begin
			spare_q <= push_angle;
		end
	end

	assign out_valid = head_v_q;
	assign out_angle = head_q;

	// Results leave in order: the spare entry is only used behind a full head.
	a_spare_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		spare_v_q |-> head_v_q)
		else $error("spare entry valid with empty head");

	// The pipeline never delivers into a full buffer.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("result pushed into full output buffer");

endmodule

@@ rtl/polynomial_atan2_approximation.sv @@
// An input transaction passes front end, divider, polynomial and buffer to m_tvalid.
// One vector per cycle unless stalled; the 16-stage divider sets most of the depth.
// A two-entry output buffer lets input transactions continue while one result waits.
// The pipeline stalls as a whole only when both buffer entries are occupied.
// Reset (arst_n low) clears all valid bits and the output buffer; no data reset.
module polynomial_atan2_approximation import patan2_pkg::*; #(
	parameter int IN_WIDTH = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// vec_x, vec_y, zero padding to whole bytes
	input  logic [((2*IN_WIDTH+7)/8)*8-1:0]       s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// angle
	output logic [OUT_W-1:0]                      m_tdata
);

	logic              en;
	logic              full;
	logic              fe_valid;
	logic [IN_WIDTH:0] fe_rem;
	logic [Q_BITS-1:0] fe_low;
	logic [IN_WIDTH:0] fe_den;
	flags_t            fe_flags;
	logic              dv_valid;
	logic [Q_BITS-1:0] dv_q;
	flags_t            dv_flags;
	logic              pl_valid;
	logic [OUT_W-1:0]  pl_angle;

	// The whole pipeline advances while the output buffer has room.
	assign en = ~full;
	assign s_tready = en;

	patan2_front #(
		.IN_WIDTH(IN_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(s_tvalid),
		.vec_x(s_tdata[IN_WIDTH-1:0]),
		.vec_y(s_tdata[2*IN_WIDTH-1:IN_WIDTH]),
		.out_valid(fe_valid),
		.out_rem(fe_rem),
		.out_low(fe_low),
		.out_den(fe_den),
		.out_flags(fe_flags)
	);

	patan2_div #(
		.IN_WIDTH(IN_WIDTH)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(fe_valid),
		.in_rem(fe_rem),
		.in_low(fe_low),
		.in_den(fe_den),
		.in_flags(fe_flags),
		.out_valid(dv_valid),
		.out_q(dv_q),
		.out_flags(dv_flags)
	);

	patan2_poly #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_poly (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(dv_valid),
		.in_q(dv_q),
		.in_flags(dv_flags),
		.out_valid(pl_valid),
		.angle(pl_angle)
	);

	patan2_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(en & pl_valid),
		.push_angle(pl_angle),
		.full(full),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_angle(m_tdata)
	);

endmodule

@@ tb/sv/polynomial_atan2_approximation_chk.sv @@
// Checker for the atan2 block: predicts each angle from input transactions and compares results.
module polynomial_atan2_approximation_chk import patan2_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	// vec_x, vec_y
	input  logic [31:0]      s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	// angle
	input  logic [OUT_W-1:0] m_tdata,
	output int               errors,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// Fixed-point constants: Q16 coefficients and pi/4 in Q61.
	localparam longint CUBE_Q16 = 64'sd12865;
	localparam longint LIN_Q16 = 64'sd64337;
	localparam longint QUARTER_PI_Q61 = 64'sh1921FB54442D1846;
	localparam int ANGLE_FRAC = 13;
	localparam int ANGLE_SHIFT = 61 - ANGLE_FRAC;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic signed [15:0]      vx;
		logic signed [15:0]      vy;
		logic signed [OUT_W-1:0] angle;
	} angle_entry_t;

	angle_entry_t angle_q[$];
	int err_cnt = 0;
	int pending_n = 0;

	assign errors = err_cnt;
	assign outstanding = pending_n;

	// Expected angle of one vector, built up in 64-bit integer arithmetic.
	function automatic logic signed [OUT_W-1:0] atan2_angle(input logic signed [15:0] vx,
			input logic signed [15:0] vy);
		longint x, y, a, num, den, mag, q, r, base, inner, sum, ang;
		x = longint'(vx);
		y = longint'(vy);
		a = ((y < 0) ? -y : y) + 1;
		if (x >= 0) begin
			num = x - a;
			den = x + a;
			base = QUARTER_PI_Q61;
		end else begin
			num = x + a;
			den = a - x;
			base = 3 * QUARTER_PI_Q61;
		end
		// Ratio in Q1.15, rounded half up by magnitude, then saturated.
		mag = (num < 0) ? -num : num;
		q = ((mag <<< 15) + (den >>> 1)) / den;
		if (num < 0) begin
			r = (q > 32768) ? -64'sd32768 : -q;
		end else begin
			r = (q > 32767) ? 64'sd32767 : q;
		end
		// Q46 inner term times r gives the Q61 polynomial.
		inner = CUBE_Q16 * (r * r) - (LIN_Q16 <<< 30);
		sum = base + inner * r;
		// Round by magnitude, half away from zero, then apply the sign.
		mag = (sum < 0) ? -sum : sum;
		ang = (mag + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
		if ((sum < 0) != (y < 0)) begin
			ang = -ang;
		end
		if (ang > 32767) begin
			ang = 32767;
		end
		if (ang < -32768) begin
			ang = -32768;
		end
		return ang[OUT_W-1:0];
	endfunction

	// Queue a prediction per input transaction and check each output transaction.
	always @(posedge clk) begin
		angle_entry_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				e.vx = s_tdata[15:0];
				e.vy = s_tdata[31:16];
				e.angle = atan2_angle(e.vx, e.vy);
				angle_q.push_back(e);
			end
			if (m_tvalid && m_tready) begin
				if (angle_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS) begin
						$display("unexpected angle transaction: got %0d",
							$signed(m_tdata));
					end
				end else begin
					e = angle_q.pop_front();
					if (m_tdata !== e.angle) begin
						err_cnt++;
						if (err_cnt <= MAX_REPORTS) begin
							$display("angle mismatch: x=%0d y=%0d expected %0d got %0d",
								e.vx, e.vy, e.angle, $signed(m_tdata));
						end
					end
				end
			end
			pending_n <= angle_q.size();
		end
	end

endmodule

@@ tb/sv/polynomial_atan2_approximation_tb.sv @@
// Top of the atan2 testbench: clock, reset, vector stimulus, output stalls and the verdict.
module polynomial_atan2_approximation_tb import patan2_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W = 16;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [31:0]      s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	int               errors;
	int               outstanding;
	int               tx_idle_pct = 0;
	int               rx_stall_pct = 0;
	int               idle_cycles = 0;

	polynomial_atan2_approximation #(
		.IN_WIDTH(IN_W),
		.ANGLE_FRAC_BITS(13)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	polynomial_atan2_approximation_chk u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.errors(errors),
		.outstanding(outstanding)
	);

	// 12 ns clock.
	initial begin
		forever #6 clk = ~clk;
	end

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// Stop the run when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offer one vector, with random gaps before it, and wait for its transaction.
	task automatic send_vec(input logic signed [15:0] vx, input logic signed [15:0] vy);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {vy, vx};
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// Hold the input off until every expected angle has come back.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	// One random component: full range, near zero, extreme, or a random magnitude.
	function automatic logic signed [15:0] rand_comp();
		logic signed [15:0] v;
		case ($urandom_range(0, 3))
			0: v = 16'($urandom());
			1: v = 16'($signed($urandom_range(0, 16)) - 8);
			2: v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: begin
				v = 16'($urandom() >> $urandom_range(1, 15));
				if ($urandom_range(0, 1)) begin
					v = -v;
				end
			end
		endcase
		return v;
	endfunction

	// Stimulus: reset, directed corners, then random vectors in four idling phases.
	initial begin
		logic signed [15:0] corners[20][2] = '{
			'{16'sd0, 16'sd0}, '{16'sh7FFF, 16'sd0}, '{16'sh8000, 16'sd0},
			'{16'sd0, 16'sh7FFF}, '{16'sd0, 16'sh8000}, '{16'sh7FFF, 16'sh7FFF},
			'{16'sh8000, 16'sh8000}, '{16'sh8000, 16'sh7FFF}, '{16'sh7FFF, 16'sh8000},
			'{16'sd1, 16'sd0}, '{-16'sd1, 16'sd0}, '{16'sd0, 16'sd1},
			'{16'sd0, -16'sd1}, '{-16'sd1, -16'sd1}, '{-16'sd1, 16'sd1},
			'{16'sd1, -16'sd1}, '{16'sd100, 16'sd0}, '{16'sd30000, 16'sd1},
			'{16'sh8000, -16'sd1}, '{-16'sd5, 16'sd5}
		};
		// Drive reset low after time zero so the asynchronous reset sees a falling edge.
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners, including the zero vector and the slightly negative sum.
		for (int i = 0; i < 20; i++) begin
			send_vec(corners[i][0], corners[i][1]);
		end
		wait_for_drain();

		// Phases: no idling, sender idle, receiver stalling, both idling a little.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 67; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 67; end
				default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_vec(rand_comp(), rand_comp());
			end
		end

		// Let the pipeline empty, then check for leftovers and late extras.
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
